FILE: sv/smtl_pkg.sv
// ----------------------------------------------------------------------------
// Two-list sort and merge: shared package
// Types and constants used by the list buffer and the top level.
// ----------------------------------------------------------------------------
package smtl_pkg;

  localparam int DATA_W         = 32;
  localparam int LIST_DEPTH_DEF = 32;

  // Per-list control from the top-level sequencer.
  typedef struct packed {
    logic wr_en;       // load transfer writes the next free entry
    logic sort_start;  // begin the exchange sort over the loaded entries
  } list_ctl_t;

  // Exchange-sort sequencer inside each list buffer.
  typedef enum logic [2:0] {
    SORT_IDLE,
    SORT_RD_P,
    SORT_LD_P,
    SORT_RD_Q,
    SORT_CMP_Q,
    SORT_WB_P
  } sort_state_t;

  // Top-level batch sequencer.
  typedef enum logic [2:0] {
    TOP_LOAD,
    TOP_START,
    TOP_WAIT,
    TOP_MRG_RD,
    TOP_MRG_PICK
  } top_state_t;

endpackage

FILE: sv/smtl_list.sv
// ----------------------------------------------------------------------------
// Two-list sort and merge: list buffer
// One list's storage with an exchange-sort sequencer around one comparator.
// ----------------------------------------------------------------------------
module smtl_list #(
  parameter int DEPTH = smtl_pkg::LIST_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smtl_pkg::list_ctl_t        ctl,
  input  logic [AW-1:0]              wr_addr,
  input  logic [smtl_pkg::DATA_W-1:0] wr_data,
  input  logic [CW-1:0]              len,
  input  logic [AW-1:0]              rd_addr,
  output logic [smtl_pkg::DATA_W-1:0] rd_data,
  output logic                       busy
);

  logic [smtl_pkg::DATA_W-1:0] mem [DEPTH];
  logic [smtl_pkg::DATA_W-1:0] rd_data_r;

  smtl_pkg::sort_state_t state_r, state_nxt;
  logic [AW-1:0]               p_r, p_nxt;
  logic [AW-1:0]               q_r, q_nxt;
  logic [smtl_pkg::DATA_W-1:0] cur_r, cur_nxt;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [smtl_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smtl_pkg::SORT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    cur_r <= cur_nxt;
  end

  // The running minimum for position p lives in cur_r; each larger entry q
  // is compared against it and the two are swapped when out of order.
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    cur_nxt   = cur_r;
    mem_we    = ctl.wr_en;
    mem_waddr = wr_addr;
    mem_wdata = wr_data;
    mem_raddr = rd_addr;
    case (state_r)
      smtl_pkg::SORT_IDLE: begin
        p_nxt = '0;
        if (ctl.sort_start && len > CW'(1)) begin
          state_nxt = smtl_pkg::SORT_RD_P;
        end
      end
      smtl_pkg::SORT_RD_P: begin
        mem_raddr = p_r;
        state_nxt = smtl_pkg::SORT_LD_P;
      end
      smtl_pkg::SORT_LD_P: begin
        cur_nxt   = rd_data_r;
        q_nxt     = p_r + AW'(1);
        state_nxt = smtl_pkg::SORT_RD_Q;
      end
      smtl_pkg::SORT_RD_Q: begin
        mem_raddr = q_r;
        state_nxt = smtl_pkg::SORT_CMP_Q;
      end
      smtl_pkg::SORT_CMP_Q: begin
        mem_raddr = q_r;
        if ($signed(cur_r) > $signed(rd_data_r)) begin
          mem_we    = 1'b1;
          mem_waddr = q_r;
          mem_wdata = cur_r;
          cur_nxt   = rd_data_r;
        end
        if (CW'(q_r) == len - CW'(1)) begin
          state_nxt = smtl_pkg::SORT_WB_P;
        end else begin
          q_nxt     = q_r + AW'(1);
          state_nxt = smtl_pkg::SORT_RD_Q;
        end
      end
      smtl_pkg::SORT_WB_P: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        mem_wdata = cur_r;
        if (CW'(p_r) == len - CW'(2)) begin
          state_nxt = smtl_pkg::SORT_IDLE;
        end else begin
          p_nxt     = p_r + AW'(1);
          state_nxt = smtl_pkg::SORT_RD_P;
        end
      end
      default: begin
        state_nxt = smtl_pkg::SORT_IDLE;
      end
    endcase
  end

  assign rd_data = rd_data_r;
  assign busy    = (state_r != smtl_pkg::SORT_IDLE);

endmodule

FILE: sv/sort_and_merge_two_lists_top.sv
// ----------------------------------------------------------------------------
// Two-list sort and merge: top level
// Loads a batch into lists A and B, sorts both and streams out the merge.
// ----------------------------------------------------------------------------
// Signed 32-bit values arrive one per transfer on the in_ channel, tagged by
// in_tuser for list A (0) or list B (1); each list holds LIST_DEPTH values,
// and a value for a full list is dropped and sets the overflow flag. Loading
// takes one transfer per cycle. The transfer with in_tlast set is stored like
// any other and closes the batch: in_tready then drops while both lists are
// sorted in parallel, each by its own exchange-sort sequencer built around
// one comparator and one buffer with one read and one write port. Sorting
// reads and compares every pair of a list's entries through that comparator
// (a list of fewer than two entries is not sorted), and the longer list sets
// the time. The merge then reads the head of each list in a read state and
// picks one result in a pick state, which waits while out_tready holds back
// the output register; ties go to list A. Results leave through that
// register, so the last result may still be waiting on out_tready while
// loading of the next batch has begun. out_tlast marks the final result and
// out_tuser carries the overflow flag on every result of the batch.
// ----------------------------------------------------------------------------
module sort_and_merge_two_lists_top #(
  parameter int LIST_DEPTH = smtl_pkg::LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] list_sel
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tuser,  // [0] overflow
  output logic        out_tlast   // last_out
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  smtl_pkg::top_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [31:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;
  logic        out_tlast_r, out_tlast_nxt;

  smtl_pkg::list_ctl_t        ctl_a, ctl_b;
  logic [31:0]                a_data, b_data;
  logic                       busy_a, busy_b;

  logic in_xfer;
  logic out_free;
  logic pick_a;

  smtl_list #(.DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_list_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (in_tdata),
    .len     (cnt_a_r),
    .rd_addr (ia_r[AW-1:0]),
    .rd_data (a_data),
    .busy    (busy_a)
  );

  smtl_list #(.DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_list_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (in_tdata),
    .len     (cnt_b_r),
    .rd_addr (ib_r[AW-1:0]),
    .rd_data (b_data),
    .busy    (busy_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= smtl_pkg::TOP_LOAD;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      drop_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      drop_r       <= drop_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    ia_r        <= ia_nxt;
    ib_r        <= ib_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign in_tready = (state_r == smtl_pkg::TOP_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // List A wins while it has entries left, unless B still has entries and
  // B's head is strictly smaller.
  assign pick_a = (ia_r < cnt_a_r) &&
                  ((ib_r >= cnt_b_r) || !($signed(a_data) > $signed(b_data)));

  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    drop_nxt       = drop_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    ctl_a          = '0;
    ctl_b          = '0;
    case (state_r)
      smtl_pkg::TOP_LOAD: begin
        ia_nxt = '0;
        ib_nxt = '0;
        if (in_xfer) begin
          if (!in_tuser) begin
            if (cnt_a_r < CW'(LIST_DEPTH)) begin
              ctl_a.wr_en = 1'b1;
              cnt_a_nxt   = cnt_a_r + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else begin
            if (cnt_b_r < CW'(LIST_DEPTH)) begin
              ctl_b.wr_en = 1'b1;
              cnt_b_nxt   = cnt_b_r + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end
          if (in_tlast) begin
            state_nxt = smtl_pkg::TOP_START;
          end
        end
      end
      smtl_pkg::TOP_START: begin
        ctl_a.sort_start = 1'b1;
        ctl_b.sort_start = 1'b1;
        state_nxt        = smtl_pkg::TOP_WAIT;
      end
      smtl_pkg::TOP_WAIT: begin
        if (!busy_a && !busy_b) begin
          if (cnt_a_r == '0 && cnt_b_r == '0) begin
            drop_nxt  = 1'b0;
            state_nxt = smtl_pkg::TOP_LOAD;
          end else begin
            state_nxt = smtl_pkg::TOP_MRG_RD;
          end
        end
      end
      smtl_pkg::TOP_MRG_RD: begin
        // Read addresses are ia_r and ib_r; the heads are valid next cycle.
        state_nxt = smtl_pkg::TOP_MRG_PICK;
      end
      smtl_pkg::TOP_MRG_PICK: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = drop_r;
          if (pick_a) begin
            out_tdata_nxt = a_data;
            ia_nxt        = ia_r + CW'(1);
          end else begin
            out_tdata_nxt = b_data;
            ib_nxt        = ib_r + CW'(1);
          end
          out_tlast_nxt = (ia_nxt == cnt_a_r) && (ib_nxt == cnt_b_r);
          if (out_tlast_nxt) begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = smtl_pkg::TOP_LOAD;
          end else begin
            state_nxt = smtl_pkg::TOP_MRG_RD;
          end
        end
      end
      default: begin
        state_nxt = smtl_pkg::TOP_LOAD;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule
